// ===== rtl/core/ssr_pkg.sv =====
// shared types and constants of the signature rrip replacement block
// used by the counter memory and the top level; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package ssr_pkg;

   // operation codes carried in the request
   typedef enum logic [1:0] {
      FUNC_VICTIM = 2'd0,
      FUNC_HIT    = 2'd1,
      FUNC_FILL   = 2'd2,
      FUNC_MARK   = 2'd3
   } func_type;

   // access kinds carried in the request
   typedef enum logic [1:0] {
      ACC_LOAD      = 2'd0,
      ACC_RFO       = 2'd1,
      ACC_PREFETCH  = 2'd2,
      ACC_WRITEBACK = 2'd3
   } access_type_type;

   // configuration register indexes
   localparam logic CSR_OVERRIDE_PCT = 1'b0;
   localparam logic CSR_PF_TRAIN_PCT = 1'b1;

   localparam int unsigned PCT_W = 7;
   localparam logic [PCT_W-1:0] OVERRIDE_PCT_RESET = 7'd0;
   localparam logic [PCT_W-1:0] PF_TRAIN_PCT_RESET = 7'd5;

   // re-reference values
   localparam int unsigned RRPV_W = 2;
   localparam logic [RRPV_W-1:0] RRPV_MAX  = 2'd3;
   localparam logic [RRPV_W-1:0] RRPV_LONG = 2'd2;
   localparam logic [RRPV_W-1:0] RRPV_ONE  = 2'd1;
   localparam logic [RRPV_W-1:0] RRPV_ZERO = 2'd0;

   // reuse counters
   localparam int unsigned CTR_W = 3;
   localparam logic [CTR_W-1:0] CTR_MAX   = 3'd7;
   localparam logic [CTR_W-1:0] CTR_ZERO  = 3'd0;
   localparam logic [CTR_W-1:0] CTR_RESET = 3'd1;

endpackage
`default_nettype wire

// ===== rtl/core/ssr_row_mem.sv =====
// per-set row memory: one read port, one write port, registered read data
// clears every row to its reset pattern after reset; no package needed
`timescale 1ns / 1ps
`default_nettype none
module ssr_row_mem #(
   parameter int unsigned DEPTH = 64,
   parameter int unsigned ROW_W = 153,
   parameter int unsigned LANES = 8
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [ROW_W-1:0]                          rd_data,
   input  wire logic                                      wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [ROW_W-1:0]                          wr_data,
   output logic                                           clr_done
);
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
   // every line at the largest rrpv, all other fields zero
   localparam logic [ROW_W-1:0] RESET_ROW = ROW_W'({LANES{2'b11}});

   logic [ROW_W-1:0] mem [DEPTH];
   logic [AW-1:0]    clr_ptr_ff;
   logic             clr_busy_ff;

   // clearing sweep, one row a cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ptr_ff  <= '0;
         clr_busy_ff <= 1'b1;
      end else if (clr_busy_ff) begin
         if (clr_ptr_ff == LAST) begin
            clr_busy_ff <= 1'b0;
         end else begin
            clr_ptr_ff <= clr_ptr_ff + 1'b1;
         end
      end
   end

   // array write and registered read
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_ptr_ff] <= RESET_ROW;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

   assign clr_done = !clr_busy_ff;

endmodule
`default_nettype wire

// ===== rtl/core/ssr_ctr_mem.sv =====
// reuse counter memory: two read ports, one write port, registered reads
// depends on ssr_pkg for the counter width and reset value
`timescale 1ns / 1ps
`default_nettype none
module ssr_ctr_mem #(
   parameter int unsigned DEPTH = 65536
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]       rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0]       rd_addr_b,
   output logic      [ssr_pkg::CTR_W-1:0]      rd_data_a,
   output logic      [ssr_pkg::CTR_W-1:0]      rd_data_b,
   input  wire logic                           wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]       wr_addr,
   input  wire logic [ssr_pkg::CTR_W-1:0]      wr_data,
   output logic                                clr_done
);
   import ssr_pkg::*;

   localparam int unsigned AW = $clog2(DEPTH);
   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

   logic [CTR_W-1:0] mem [DEPTH];
   logic [AW-1:0]    clr_ptr_ff;
   logic             clr_busy_ff;

   // clearing sweep, one counter a cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ptr_ff  <= '0;
         clr_busy_ff <= 1'b1;
      end else if (clr_busy_ff) begin
         if (clr_ptr_ff == LAST) begin
            clr_busy_ff <= 1'b0;
         end else begin
            clr_ptr_ff <= clr_ptr_ff + 1'b1;
         end
      end
   end

   // array write and two registered reads
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_ptr_ff] <= CTR_RESET;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

   assign clr_done = !clr_busy_ff;

endmodule
`default_nettype wire

// ===== rtl/core/signature_rrip_replacement.sv =====
// signature based rrip replacement top level: sequencer and line update logic
// depends on ssr_pkg, ssr_row_mem and ssr_ctr_mem
`timescale 1ns / 1ps
`default_nettype none
// Each request goes from acceptance to result in order: it reads the set row
// (all ways of the set plus its sampled flag) from the row memory, then reads
// the two reuse counters that the line can touch from the counter memory, and
// then updates the line and writes back the row and any trained counter. The next
// request is taken once the result has moved into the output register, so a
// stalled result holds the block in its update step. After reset the block
// runs a clearing pass over all CORES * 2**SIG_BITS counters (65536 by default)
// of the counter memory and clears the row memory alongside; req_tready stays
// low until both passes end. Configuration writes are taken at any time.
module signature_rrip_replacement #(
   parameter int unsigned SETS     = 64,
   parameter int unsigned WAYS     = 8,
   parameter int unsigned CORES    = 4,
   parameter int unsigned SIG_BITS = 14
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // func, set_index, way_index, core_id, pc_low, access_type, chance
   input  wire logic [39:0] req_tdata,
   // response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // way_out, rrpv_out
   output logic [7:0]       rsp_tdata,
   // configuration
   input  wire logic        csr_we,
   input  wire logic        csr_addr,
   input  wire logic [6:0]  csr_wdata
);
   import ssr_pkg::*;

   localparam int unsigned SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int unsigned WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int unsigned CORE_W = (CORES > 1) ? $clog2(CORES) : 1;
   localparam int unsigned CDEPTH = CORES << SIG_BITS;
   localparam int unsigned CIDX_W = $clog2(CDEPTH);
   localparam int unsigned PF_LO  = RRPV_W * WAYS;
   localparam int unsigned RU_LO  = PF_LO + WAYS;
   localparam int unsigned SG_LO  = RU_LO + WAYS;
   localparam int unsigned FC_LO  = SG_LO + WAYS * SIG_BITS;
   localparam int unsigned SMP_B  = FC_LO + WAYS * CORE_W;
   localparam int unsigned ROW_W  = SMP_B + 1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_ROW,
      S_CTR
   } state_type;

   // wrap a narrow index by a constant through compare and subtract
   function automatic logic [5:0] wrap_idx(input logic [5:0] v, input int unsigned m);
      logic [5:0] r;
      r = v;
      for (int k = 5; k >= 0; k--) begin
         if (32'(r) >= (m << k)) begin
            r = r - 6'(m << k);
         end
      end
      return r;
   endfunction

   state_type             state_ff;
   func_type              func_ff;
   access_type_type       acc_ff;
   logic [SET_W-1:0]      set_ff;
   logic [WAY_W-1:0]      way_ff;
   logic [CORE_W-1:0]     core_ff;
   logic [12:0]           pc_ff;
   logic [PCT_W-1:0]      chance_ff;
   logic [PCT_W-1:0]      override_pct_ff;
   logic [PCT_W-1:0]      pf_train_pct_ff;
   logic [CIDX_W-1:0]     ctr_a_addr_ff;
   logic [CIDX_W-1:0]     ctr_b_addr_ff;
   logic                  rsp_valid_ff;
   logic [7:0]            rsp_data_ff;

   logic                  req_fire;
   logic                  out_free;
   logic                  finish;
   logic                  row_clr_done;
   logic                  ctr_clr_done;
   logic [ROW_W-1:0]      row_q;
   logic [ROW_W-1:0]      row_n;
   logic [CTR_W-1:0]      ctr_a;
   logic [CTR_W-1:0]      ctr_b;
   logic [CTR_W-1:0]      ctr_wd;
   logic                  ctr_we;
   logic [CIDX_W-1:0]     ctr_a_addr;
   logic [CIDX_W-1:0]     ctr_b_addr;
   logic [SIG_BITS-1:0]   new_sig;
   logic                  is_pf;
   logic [RRPV_W-1:0]     out_rr;
   logic [WAY_W-1:0]      victim;

   logic [RRPV_W-1:0]     rr_q [WAYS];
   logic                  pf_q [WAYS];
   logic                  ru_q [WAYS];
   logic [SIG_BITS-1:0]   sg_q [WAYS];
   logic [CORE_W-1:0]     fc_q [WAYS];
   logic [RRPV_W-1:0]     rr_n [WAYS];
   logic                  pf_n [WAYS];
   logic                  ru_n [WAYS];
   logic [SIG_BITS-1:0]   sg_n [WAYS];
   logic [CORE_W-1:0]     fc_n [WAYS];
   logic                  smp_q;
   logic                  smp_n;

   assign req_fire   = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE) && row_clr_done && ctr_clr_done;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign finish     = (state_ff == S_CTR) && out_free;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // signature of the request
   assign is_pf   = (acc_ff == ACC_PREFETCH);
   assign new_sig = SIG_BITS'({3'b000, pc_ff, is_pf});

   // unpack the set row and pack the updated one
   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         rr_q[w] = row_q[RRPV_W*w +: RRPV_W];
         pf_q[w] = row_q[PF_LO + w];
         ru_q[w] = row_q[RU_LO + w];
         sg_q[w] = row_q[SG_LO + SIG_BITS*w +: SIG_BITS];
         fc_q[w] = row_q[FC_LO + CORE_W*w +: CORE_W];
      end
      smp_q = row_q[SMP_B];
   end

   always_comb begin
      row_n = '0;
      for (int w = 0; w < WAYS; w++) begin
         row_n[RRPV_W*w +: RRPV_W]              = rr_n[w];
         row_n[PF_LO + w]                       = pf_n[w];
         row_n[RU_LO + w]                       = ru_n[w];
         row_n[SG_LO + SIG_BITS*w +: SIG_BITS]  = sg_n[w];
         row_n[FC_LO + CORE_W*w +: CORE_W]      = fc_n[w];
      end
      row_n[SMP_B] = smp_n;
   end

   // counter addresses: the line's recorded owner and the new signature
   assign ctr_a_addr = CIDX_W'({fc_q[way_ff], sg_q[way_ff]});
   assign ctr_b_addr = CIDX_W'({core_ff, new_sig});

   // line update for the current operation
   always_comb begin
      logic [RRPV_W-1:0] mx;
      logic [RRPV_W-1:0] age;
      logic [CTR_W-1:0]  a_inc;
      logic [CTR_W-1:0]  a_dec;
      logic [CTR_W-1:0]  c;
      logic              any3;
      logic              any2;
      logic              any1;

      rr_n   = rr_q;
      pf_n   = pf_q;
      ru_n   = ru_q;
      sg_n   = sg_q;
      fc_n   = fc_q;
      smp_n  = smp_q;
      ctr_we = 1'b0;
      a_inc  = (ctr_a == CTR_MAX) ? CTR_MAX : ctr_a + 1'b1;
      a_dec  = (ctr_a == CTR_ZERO) ? CTR_ZERO : ctr_a - 1'b1;
      ctr_wd = a_inc;
      c      = ctr_b;

      // largest rrpv of the set and the first way holding it
      any3 = 1'b0;
      any2 = 1'b0;
      any1 = 1'b0;
      for (int w = 0; w < WAYS; w++) begin
         any3 = any3 | (rr_q[w] == RRPV_MAX);
         any2 = any2 | (rr_q[w] == RRPV_LONG);
         any1 = any1 | (rr_q[w] == RRPV_ONE);
      end
      priority if (any3) mx = RRPV_MAX;
      else if (any2)     mx = RRPV_LONG;
      else if (any1)     mx = RRPV_ONE;
      else               mx = RRPV_ZERO;
      age    = RRPV_MAX - mx;
      victim = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (rr_q[w] == mx) begin
            victim = WAY_W'(w);
         end
      end

      unique case (func_ff)
         FUNC_VICTIM: begin
            for (int w = 0; w < WAYS; w++) begin
               rr_n[w] = rr_q[w] + age;
            end
         end
         FUNC_HIT: begin
            if (acc_ff != ACC_WRITEBACK) begin
               if (is_pf && pf_q[way_ff]) begin
                  if (smp_q && (chance_ff < pf_train_pct_ff)) begin
                     ctr_we       = 1'b1;
                     ru_n[way_ff] = 1'b1;
                  end
               end else begin
                  rr_n[way_ff] = pf_q[way_ff] ? RRPV_MAX : RRPV_ZERO;
                  pf_n[way_ff] = 1'b0;
                  if (smp_q && !ru_q[way_ff]) begin
                     ctr_we       = 1'b1;
                     ru_n[way_ff] = 1'b1;
                  end
               end
            end
         end
         FUNC_FILL: begin
            if (smp_q) begin
               ctr_we       = 1'b1;
               ctr_wd       = ru_q[way_ff] ? a_inc : a_dec;
               ru_n[way_ff] = 1'b0;
               sg_n[way_ff] = new_sig;
               fc_n[way_ff] = core_ff;
               // the prediction sees the training of the same counter
               if (ctr_a_addr_ff == ctr_b_addr_ff) begin
                  c = ctr_wd;
               end
            end
            pf_n[way_ff] = is_pf;
            priority if (acc_ff == ACC_WRITEBACK) rr_n[way_ff] = RRPV_MAX;
            else if (c == CTR_ZERO)
               rr_n[way_ff] = (chance_ff >= override_pct_ff) ? RRPV_MAX : RRPV_LONG;
            else if (c == CTR_MAX)
               rr_n[way_ff] = is_pf ? RRPV_ONE : RRPV_ZERO;
            else
               rr_n[way_ff] = RRPV_LONG;
         end
         FUNC_MARK: begin
            smp_n = 1'b1;
         end
         default: begin
            smp_n = smp_q;
         end
      endcase

      out_rr = (func_ff == FUNC_VICTIM) ? RRPV_MAX : rr_n[way_ff];
   end

   // sequencer, configuration and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         rsp_valid_ff    <= 1'b0;
         override_pct_ff <= OVERRIDE_PCT_RESET;
         pf_train_pct_ff <= PF_TRAIN_PCT_RESET;
      end else begin
         if (csr_we) begin
            unique case (csr_addr)
               CSR_OVERRIDE_PCT: override_pct_ff <= csr_wdata;
               CSR_PF_TRAIN_PCT: pf_train_pct_ff <= csr_wdata;
               default:          override_pct_ff <= override_pct_ff;
            endcase
         end
         if (rsp_valid_ff && rsp_tready && !finish) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  func_ff   <= func_type'(req_tdata[1:0]);
                  set_ff    <= SET_W'(wrap_idx(req_tdata[7:2], SETS));
                  way_ff    <= WAY_W'(wrap_idx({3'b000, req_tdata[10:8]}, WAYS));
                  core_ff   <= CORE_W'(wrap_idx({4'b0000, req_tdata[12:11]}, CORES));
                  pc_ff     <= req_tdata[25:13];
                  acc_ff    <= access_type_type'(req_tdata[27:26]);
                  chance_ff <= req_tdata[34:28];
                  state_ff  <= S_ROW;
               end
            end
            S_ROW: begin
               ctr_a_addr_ff <= ctr_a_addr;
               ctr_b_addr_ff <= ctr_b_addr;
               state_ff      <= S_CTR;
            end
            S_CTR: begin
               if (out_free) begin
                  rsp_data_ff  <= {3'b000, out_rr,
                                   3'((func_ff == FUNC_VICTIM) ? victim : way_ff)};
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   ssr_row_mem #(
      .DEPTH (SETS),
      .ROW_W (ROW_W),
      .LANES (WAYS)
   ) u_row_mem (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (req_fire),
      .rd_addr  (SET_W'(wrap_idx(req_tdata[7:2], SETS))),
      .rd_data  (row_q),
      .wr_en    (finish),
      .wr_addr  (set_ff),
      .wr_data  (row_n),
      .clr_done (row_clr_done)
   );

   ssr_ctr_mem #(
      .DEPTH (CDEPTH)
   ) u_ctr_mem (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (state_ff == S_ROW),
      .rd_addr_a (ctr_a_addr),
      .rd_addr_b (ctr_b_addr),
      .rd_data_a (ctr_a),
      .rd_data_b (ctr_b),
      .wr_en     (finish && ctr_we),
      .wr_addr   (ctr_a_addr_ff),
      .wr_data   (ctr_wd),
      .clr_done  (ctr_clr_done)
   );

   // no transaction is taken before both clearing sweeps end
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> (row_clr_done && ctr_clr_done))
      else $error("request accepted during clearing pass");

   // an accepted transaction reads its row and then its counters
   a_seq_order: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == S_ROW) ##1 (state_ff == S_CTR))
      else $error("sequencer skipped a memory read");

   // a victim result always carries the largest rrpv
   a_victim_rrpv: assert property (@(posedge clock) disable iff (reset)
      (finish && (func_ff == FUNC_VICTIM)) |=> (rsp_data_ff[4:3] == RRPV_MAX))
      else $error("victim result without largest rrpv");

   // a result is never overwritten while it waits
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      finish |-> (!rsp_valid_ff || rsp_tready))
      else $error("pending result overwritten");

endmodule
`default_nettype wire
